[rtl/fdm_pkg.sv]
// Shared constants, types and codes for the frame-difference motion counter.
// No dependencies; every other file of the block imports it.
package fdm_pkg;

	// sizing
	localparam int MAX_SAMPLES = 4096;
	localparam int MAX_WIDTH   = 4096;

	localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
	localparam int IDX_W     = $clog2(MAX_SAMPLES);
	localparam int ADDR_W    = IDX_W + 1;              // bank bit + sample index
	localparam int RAM_DEPTH = 2 * MAX_SAMPLES;

	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = 12;                     // row counter wraps at 4096
	localparam int WIDTH_W   = 13;
	localparam int CMP_W     = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
	localparam int STRIDE_W  = 5;
	localparam int RS_STEPS  = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int RS_CNT_W  = $clog2(RS_STEPS + 1);

	localparam int PIX_W     = 8;
	localparam int DIFF_W    = 9;
	localparam int MEAN_W    = 9;
	localparam int THR_W     = 8;
	localparam int RATIO_W   = 17;
	localparam int FRAC_W    = 16;
	localparam int TIME_W    = 32;
	localparam int PROD_W    = RATIO_W + CNT_W;

	localparam int TOTAL_W   = DIFF_W + IDX_W + 1;
	localparam int MAG_W     = TOTAL_W - 1;
	localparam int DIV_CNT_W = $clog2(MAG_W + 1);

	localparam int JOBQ_DEPTH = 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH,
		REG_SAMPLE_STRIDE,
		REG_DIFF_THRESHOLD,
		REG_MIN_RATIO,
		REG_COOLDOWN
	} cfg_reg_t;

	localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH = 13'd320;
	localparam logic [STRIDE_W-1:0] RST_STRIDE      = 5'd4;
	localparam logic [THR_W-1:0]    RST_THRESHOLD   = 8'd20;
	localparam logic [RATIO_W-1:0]  RST_MIN_RATIO   = 17'd3277;
	localparam logic [TIME_W-1:0]   RST_COOLDOWN    = 32'd1000;

	// frame-end job handed from front to back
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [CNT_W-1:0]   count;
		logic               ovf;
		logic [TIME_W-1:0]  now;
		logic               bank;
	} job_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [DIFF_W-1:0] data;
	} ram_wr_t;

	// back part hands a bank back to the front when its job is done
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_rel_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_SCAN,
		B_MULT,
		B_JUDGE
	} back_state_t;

endpackage

[rtl/fdm_diff_ram.sv]
// Two-bank sample difference store, one write port and one registered read port.
// Depends on fdm_pkg.
module fdm_diff_ram (
	input  logic                          clk,
	input  fdm_pkg::ram_wr_t              wr,
	input  logic                          rd_en,
	input  logic [fdm_pkg::ADDR_W-1:0]    rd_addr,
	output logic [fdm_pkg::DIFF_W-1:0]    rd_data
);
	import fdm_pkg::*;

	logic [DIFF_W-1:0] mem [RAM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/fdm_job_queue.sv]
// Two-entry queue of frame-end jobs between the front and back parts.
// Depends on fdm_pkg.
module fdm_job_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fdm_pkg::job_t job_in,
	output logic          full,
	input  logic          pop,
	output fdm_pkg::job_t job_out,
	output logic          empty
);
	import fdm_pkg::*;

	localparam int PTR_W = $clog2(JOBQ_DEPTH);

	job_t             entry_q [JOBQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;

	assign full    = (fill_q == (PTR_W+1)'(JOBQ_DEPTH));
	assign empty   = (fill_q == '0);
	assign job_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[rtl/fdm_front.sv]
// Front part: takes pixel beats, tracks raster position and sampling phase,
// stores sampled differences and raises a job at frame end. Depends on fdm_pkg.
module fdm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [fdm_pkg::PIX_W-1:0]     prev_pixel,
	input  logic [fdm_pkg::PIX_W-1:0]     curr_pixel,
	input  logic                          end_of_frame,
	input  logic [fdm_pkg::TIME_W-1:0]    frame_time_ms,
	input  logic [fdm_pkg::WIDTH_W-1:0]   frame_width,
	input  logic [fdm_pkg::STRIDE_W-1:0]  sample_stride,
	input  logic                          stride_changed,
	output fdm_pkg::ram_wr_t              ram_wr,
	output fdm_pkg::job_t                 job,
	output logic                          job_push,
	input  logic                          job_full,
	input  fdm_pkg::bank_rel_t            bank_rel
);
	import fdm_pkg::*;

	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [STRIDE_W-1:0] col_ph_q;
	logic [STRIDE_W-1:0] row_ph_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [CNT_W-1:0]    count_q;
	logic                ovf_q;
	logic                bank_q;
	logic [1:0]          busy_q;

	// phase recompute after a stride change
	logic                resync_q;
	logic [RS_CNT_W-1:0] rs_cnt_q;
	logic [RS_STEPS-1:0] col_sh_q;
	logic [RS_STEPS-1:0] row_sh_q;
	logic [STRIDE_W-1:0] col_rem_q;
	logic [STRIDE_W-1:0] row_rem_q;

	logic [CMP_W-1:0]    width_eff;
	logic [STRIDE_W-1:0] stride_eff;
	logic [STRIDE_W-1:0] stride_m1;
	logic                accept;
	logic                sampled;
	logic                room;
	logic                store;
	logic [DIFF_W-1:0]   diff;
	logic [TOTAL_W-1:0]  total_nx;
	logic [CNT_W-1:0]    count_nx;
	logic                ovf_nx;
	logic                row_end;
	logic [STRIDE_W-1:0] col_rem_nx;
	logic [STRIDE_W-1:0] row_rem_nx;
	logic [1:0]          busy_set;
	logic [1:0]          busy_clr;

	function automatic logic [STRIDE_W-1:0] mod_step(
		input logic [STRIDE_W-1:0] rem,
		input logic                nbit,
		input logic [STRIDE_W-1:0] div
	);
		logic [STRIDE_W:0] trial;
		trial = {rem, nbit};
		if (trial >= {1'b0, div}) begin
			trial = trial - {1'b0, div};
		end
		return trial[STRIDE_W-1:0];
	endfunction

	always_comb begin
		if (frame_width == '0) begin
			width_eff = CMP_W'(1);
		end else if (CMP_W'(frame_width) > CMP_W'(MAX_WIDTH)) begin
			width_eff = CMP_W'(MAX_WIDTH);
		end else begin
			width_eff = CMP_W'(frame_width);
		end
	end

	assign stride_eff = (sample_stride == '0) ? STRIDE_W'(1) : sample_stride;
	assign stride_m1  = stride_eff - 1'b1;

	assign in_stall = resync_q || stride_changed || busy_q[bank_q] || job_full;
	assign accept   = in_valid && !in_stall;

	assign sampled = (col_ph_q == '0) && (row_ph_q == '0);
	assign room    = (count_q < CNT_W'(MAX_SAMPLES));
	assign store   = accept && sampled && room;
	assign diff    = {1'b0, curr_pixel} - {1'b0, prev_pixel};

	assign total_nx = store ? total_q + {{(TOTAL_W-DIFF_W){diff[DIFF_W-1]}}, diff} : total_q;
	assign count_nx = store ? count_q + 1'b1 : count_q;
	assign ovf_nx   = ovf_q || (accept && sampled && !room);
	assign row_end  = (CMP_W'(col_q) + CMP_W'(1)) >= width_eff;

	assign ram_wr.en   = store;
	assign ram_wr.addr = {bank_q, count_q[IDX_W-1:0]};
	assign ram_wr.data = diff;

	assign job_push  = accept && end_of_frame;
	assign job.total = total_nx;
	assign job.count = count_nx;
	assign job.ovf   = ovf_nx;
	assign job.now   = frame_time_ms;
	assign job.bank  = bank_q;

	assign col_rem_nx = mod_step(col_rem_q, col_sh_q[RS_STEPS-1], stride_eff);
	assign row_rem_nx = mod_step(row_rem_q, row_sh_q[RS_STEPS-1], stride_eff);

	assign busy_set = job_push ? (2'b01 << bank_q) : 2'b00;
	assign busy_clr = bank_rel.valid ? (2'b01 << bank_rel.bank) : 2'b00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			col_ph_q  <= '0;
			row_ph_q  <= '0;
			total_q   <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			bank_q    <= 1'b0;
			busy_q    <= '0;
			resync_q  <= 1'b0;
			rs_cnt_q  <= '0;
			col_sh_q  <= '0;
			row_sh_q  <= '0;
			col_rem_q <= '0;
			row_rem_q <= '0;
		end else begin
			busy_q <= (busy_q | busy_set) & ~busy_clr;
			if (accept) begin
				if (end_of_frame) begin
					col_q    <= '0;
					row_q    <= '0;
					col_ph_q <= '0;
					row_ph_q <= '0;
					total_q  <= '0;
					count_q  <= '0;
					ovf_q    <= 1'b0;
					bank_q   <= ~bank_q;
				end else begin
					total_q <= total_nx;
					count_q <= count_nx;
					ovf_q   <= ovf_nx;
					if (row_end) begin
						col_q    <= '0;
						col_ph_q <= '0;
						row_q    <= row_q + 1'b1;
						if (row_q == '1 || row_ph_q == stride_m1) begin
							row_ph_q <= '0;
						end else begin
							row_ph_q <= row_ph_q + 1'b1;
						end
					end else begin
						col_q    <= col_q + 1'b1;
						col_ph_q <= (col_ph_q == stride_m1) ? '0 : col_ph_q + 1'b1;
					end
				end
			end else if (stride_changed) begin
				resync_q  <= 1'b1;
				rs_cnt_q  <= RS_CNT_W'(RS_STEPS);
				col_sh_q  <= RS_STEPS'(col_q);
				row_sh_q  <= RS_STEPS'(row_q);
				col_rem_q <= '0;
				row_rem_q <= '0;
			end else if (resync_q) begin
				col_rem_q <= col_rem_nx;
				row_rem_q <= row_rem_nx;
				col_sh_q  <= col_sh_q << 1;
				row_sh_q  <= row_sh_q << 1;
				rs_cnt_q  <= rs_cnt_q - 1'b1;
				if (rs_cnt_q == RS_CNT_W'(1)) begin
					resync_q <= 1'b0;
					col_ph_q <= col_rem_nx;
					row_ph_q <= row_rem_nx;
				end
			end
		end
	end

endmodule

[rtl/fdm_back.sv]
// Back part: per frame job, divides for the mean shift, scans the stored
// differences, judges the ratio and cooldown, holds the result. Depends on fdm_pkg.
module fdm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fdm_pkg::job_t                 job,
	input  logic                          job_empty,
	output logic                          job_pop,
	output logic                          rd_en,
	output logic [fdm_pkg::ADDR_W-1:0]    rd_addr,
	input  logic [fdm_pkg::DIFF_W-1:0]    rd_data,
	input  logic [fdm_pkg::THR_W-1:0]     diff_threshold,
	input  logic [fdm_pkg::RATIO_W-1:0]   min_ratio_q16,
	input  logic [fdm_pkg::TIME_W-1:0]    cooldown,
	output fdm_pkg::bank_rel_t            bank_rel,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fdm_pkg::CNT_W-1:0]     moving_count,
	output logic [fdm_pkg::CNT_W-1:0]     sample_count,
	output logic signed [fdm_pkg::MEAN_W-1:0] mean_shift,
	output logic                          motion_detected,
	output logic                          motion_reported,
	output logic                          sample_overflow
);
	import fdm_pkg::*;

	back_state_t state_q, state_d;

	logic                neg_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                ovf_q;
	logic [TIME_W-1:0]   now_q;
	logic                bank_q;
	logic [CNT_W-1:0]    rem_q;
	logic [MAG_W-1:0]    dq_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [MEAN_W-1:0]   mean_q;
	logic [CNT_W-1:0]    idx_q;
	logic                rd_vld_s1;
	logic [CNT_W-1:0]    moving_q;
	logic [PROD_W-1:0]   prod_q;
	logic                has_rep_q;
	logic [TIME_W-1:0]   last_q;

	logic                out_valid_q;
	logic [CNT_W-1:0]    moving_out_q;
	logic [CNT_W-1:0]    samples_out_q;
	logic [MEAN_W-1:0]   mean_out_q;
	logic                det_out_q;
	logic                rep_out_q;
	logic                ovf_out_q;

	logic [TOTAL_W-1:0]  total_abs;
	logic [CNT_W:0]      trial;
	logic                ge;
	logic [CNT_W-1:0]    rem_nx;
	logic [MAG_W-1:0]    q_nx;
	logic [MEAN_W-1:0]   mean_nx;
	logic [DIFF_W:0]     dm;
	logic [DIFF_W:0]     dm_abs;
	logic                is_moving;
	logic                detected;
	logic                reported;
	logic                slot_free;
	logic                done;
	logic                scan_more;

	assign total_abs = job.total[TOTAL_W-1] ? -job.total : job.total;

	// restoring divide, one quotient bit per cycle
	assign trial   = {rem_q, dq_q[MAG_W-1]};
	assign ge      = trial >= {1'b0, cnt_q};
	assign rem_nx  = ge ? CNT_W'(trial - {1'b0, cnt_q}) : CNT_W'(trial);
	assign q_nx    = {dq_q[MAG_W-2:0], ge};
	assign mean_nx = neg_q ? -q_nx[MEAN_W-1:0] : q_nx[MEAN_W-1:0];

	assign scan_more = (idx_q < cnt_q);
	assign rd_addr   = {bank_q, idx_q[IDX_W-1:0]};

	assign dm        = {rd_data[DIFF_W-1], rd_data} - {mean_q[MEAN_W-1], mean_q};
	assign dm_abs    = dm[DIFF_W] ? -dm : dm;
	assign is_moving = dm_abs > (DIFF_W+1)'(diff_threshold);

	assign detected  = (cnt_q != '0) && (PROD_W'({moving_q, {FRAC_W{1'b0}}}) >= prod_q);
	assign reported  = detected && (!has_rep_q || (now_q - last_q) >= cooldown);
	assign slot_free = !out_valid_q || !out_stall;

	assign bank_rel.valid = done;
	assign bank_rel.bank  = bank_q;

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		rd_en   = 1'b0;
		done    = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					state_d = (job.count == '0) ? B_MULT : B_DIV;
				end
			end
			B_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(1)) begin
					state_d = B_SCAN;
				end
			end
			B_SCAN: begin
				rd_en = scan_more;
				if (!scan_more && !rd_vld_s1) begin
					state_d = B_MULT;
				end
			end
			B_MULT: begin
				state_d = B_JUDGE;
			end
			B_JUDGE: begin
				if (slot_free) begin
					done    = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (job_pop) begin
					neg_q     <= job.total[TOTAL_W-1];
					cnt_q     <= job.count;
					ovf_q     <= job.ovf;
					now_q     <= job.now;
					bank_q    <= job.bank;
					rem_q     <= '0;
					dq_q      <= total_abs[MAG_W-1:0];
					div_cnt_q <= DIV_CNT_W'(MAG_W);
					mean_q    <= '0;
					moving_q  <= '0;
					idx_q     <= '0;
				end
			end
			B_DIV: begin
				rem_q     <= rem_nx;
				dq_q      <= q_nx;
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == DIV_CNT_W'(1)) begin
					mean_q <= mean_nx;
				end
			end
			B_SCAN: begin
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
				if (rd_vld_s1 && is_moving) begin
					moving_q <= moving_q + 1'b1;
				end
			end
			B_MULT: begin
				prod_q <= min_ratio_q16 * cnt_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (done) begin
			moving_out_q  <= moving_q;
			samples_out_q <= cnt_q;
			mean_out_q    <= mean_q;
			det_out_q     <= detected;
			rep_out_q     <= reported;
			ovf_out_q     <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			has_rep_q   <= 1'b0;
			last_q      <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (done) begin
				out_valid_q <= 1'b1;
				if (reported) begin
					has_rep_q <= 1'b1;
					last_q    <= now_q;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign moving_count    = moving_out_q;
	assign sample_count    = samples_out_q;
	assign mean_shift      = mean_out_q;
	assign motion_detected = det_out_q;
	assign motion_reported = rep_out_q;
	assign sample_overflow = ovf_out_q;

endmodule

[rtl/frame_diff_motion_counter.sv]
// Top level of the frame-difference motion counter: configuration registers,
// front part, job queue, two-bank difference store and back part. Depends on fdm_pkg.
//
// Pixel beats (previous and current luma, raster order) are taken one per cycle
// while in_stall is low. Every pixel whose row and column are multiples of
// sample_stride has its signed difference stored and summed, up to MAX_SAMPLES
// per frame; a beat with end_of_frame set closes the frame and yields exactly
// one result beat. The frame-end work runs in a separate back part: a restoring
// divide for the mean shift, a pass over the stored samples through the store's
// registered read port, then a multiply and a judgement of ratio and cooldown.
// Meanwhile the front keeps taking the next frame into the other bank of the
// store; input stalls only when a frame ends and its successor's bank is still
// owned by an unfinished job, when the job queue is full, or while the sampling
// phase is rederived from the current raster position after a write to
// sample_stride. The store needs no clearing pass: only entries written in the
// current frame are read. Results wait in an output register, so a stalled
// consumer holds up the back part, and pixel intake only once the banks or the
// job queue fill.
module frame_diff_motion_counter (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [fdm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fdm_pkg::CFG_DATA_W-1:0]    cfg_data,
	// pixel channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [fdm_pkg::PIX_W-1:0]         prev_pixel,
	input  logic [fdm_pkg::PIX_W-1:0]         curr_pixel,
	input  logic                              end_of_frame,
	input  logic [fdm_pkg::TIME_W-1:0]        frame_time_ms,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [fdm_pkg::CNT_W-1:0]         moving_count,
	output logic [fdm_pkg::CNT_W-1:0]         sample_count,
	output logic signed [fdm_pkg::MEAN_W-1:0] mean_shift,
	output logic                              motion_detected,
	output logic                              motion_reported,
	output logic                              sample_overflow
);
	import fdm_pkg::*;

	// configuration registers
	logic [WIDTH_W-1:0]  frame_width_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [THR_W-1:0]    threshold_q;
	logic [RATIO_W-1:0]  min_ratio_q;
	logic [TIME_W-1:0]   cooldown_q;
	logic                stride_changed_q;  // one-cycle note to the front

	ram_wr_t             ram_wr;
	job_t                job_in;
	job_t                job_head;
	logic                job_push;
	logic                job_pop;
	logic                job_full;
	logic                job_empty;
	bank_rel_t           bank_rel;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic [DIFF_W-1:0]   rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= RST_FRAME_WIDTH;
			stride_q         <= RST_STRIDE;
			threshold_q      <= RST_THRESHOLD;
			min_ratio_q      <= RST_MIN_RATIO;
			cooldown_q       <= RST_COOLDOWN;
			stride_changed_q <= 1'b0;
		end else begin
			stride_changed_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_FRAME_WIDTH:    frame_width_q <= cfg_data[WIDTH_W-1:0];
					REG_SAMPLE_STRIDE: begin
						stride_q         <= cfg_data[STRIDE_W-1:0];
						stride_changed_q <= 1'b1;
					end
					REG_DIFF_THRESHOLD: threshold_q   <= cfg_data[THR_W-1:0];
					REG_MIN_RATIO:      min_ratio_q   <= cfg_data[RATIO_W-1:0];
					REG_COOLDOWN:       cooldown_q    <= cfg_data[TIME_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	fdm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.prev_pixel     (prev_pixel),
		.curr_pixel     (curr_pixel),
		.end_of_frame   (end_of_frame),
		.frame_time_ms  (frame_time_ms),
		.frame_width    (frame_width_q),
		.sample_stride  (stride_q),
		.stride_changed (stride_changed_q),
		.ram_wr         (ram_wr),
		.job            (job_in),
		.job_push       (job_push),
		.job_full       (job_full),
		.bank_rel       (bank_rel)
	);

	fdm_job_queue u_job_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.job_in  (job_in),
		.full    (job_full),
		.pop     (job_pop),
		.job_out (job_head),
		.empty   (job_empty)
	);

	fdm_diff_ram u_diff_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fdm_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job             (job_head),
		.job_empty       (job_empty),
		.job_pop         (job_pop),
		.rd_en           (rd_en),
		.rd_addr         (rd_addr),
		.rd_data         (rd_data),
		.diff_threshold  (threshold_q),
		.min_ratio_q16   (min_ratio_q),
		.cooldown        (cooldown_q),
		.bank_rel        (bank_rel),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.moving_count    (moving_count),
		.sample_count    (sample_count),
		.mean_shift      (mean_shift),
		.motion_detected (motion_detected),
		.motion_reported (motion_reported),
		.sample_overflow (sample_overflow)
	);

	// a frame-end job is never pushed into a full queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into full queue");

	// a new result beat only follows a finished back-part job
	a_result_from_job: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(bank_rel.valid))
		else $error("result raised without a finished job");

	// a report needs a detection
	a_report_needs_detect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && motion_reported |-> motion_detected)
		else $error("motion reported without detection");

	// stored count never exceeds the store's capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sample_count <= CNT_W'(MAX_SAMPLES)))
		else $error("sample count beyond capacity");

endmodule

[bench/tb_frame_diff_motion_counter.sv]
// Self-checking bench for frame_diff_motion_counter: directed and random frames
// are checked beat by beat against an untimed model of the block.
// Depends on fdm_pkg and the block's RTL.
module tb_frame_diff_motion_counter;
	timeunit 1ns;
	timeprecision 1ps;
	import fdm_pkg::*;

	// Run sizing. A correct run covers four frames of ~4100 pixels, ~1500 random
	// pixels, one long receiver hold and a settle wait after each phase; the
	// watchdog stops a run that overruns CYCLE_LIMIT.
	localparam int CYCLE_LIMIT   = 500_000;
	localparam int RANDOM_PIXELS = 1500;
	localparam int SETTLE_CYCLES = 64;    // back part tail after the last result
	localparam int HOLD_CYCLES   = 2500;  // long receiver hold-off
	localparam int MAX_SHOWN     = 10;
	localparam int NUM_REGS      = int'(REG_COOLDOWN) + 1;

	// Pixel content of a generated frame
	typedef enum {
		SCENE_NOISE,    // unrelated previous and current luma
		SCENE_LIT,      // global brightness shift, a few moving pixels
		SCENE_EXTREME   // luma pinned at 0 or 255
	} scene_t;

	typedef struct packed {
		logic [CNT_W-1:0]  moving;
		logic [CNT_W-1:0]  samples;
		logic [MEAN_W-1:0] mean;
		logic              detected;
		logic              reported;
		logic              overflow;
	} frame_report_t;

	// ---------------------------------------------------------------- DUT
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  in_valid      = 1'b0;
	logic                  in_stall;
	logic [PIX_W-1:0]      prev_pixel    = '0;
	logic [PIX_W-1:0]      curr_pixel    = '0;
	logic                  end_of_frame  = 1'b0;
	logic [TIME_W-1:0]     frame_time_ms = '0;
	logic                  out_valid;
	logic                  out_stall     = 1'b0;
	logic [CNT_W-1:0]      moving_count;
	logic [CNT_W-1:0]      sample_count;
	logic [MEAN_W-1:0]     mean_shift;
	logic                  motion_detected;
	logic                  motion_reported;
	logic                  sample_overflow;

	frame_diff_motion_counter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.prev_pixel      (prev_pixel),
		.curr_pixel      (curr_pixel),
		.end_of_frame    (end_of_frame),
		.frame_time_ms   (frame_time_ms),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.moving_count    (moving_count),
		.sample_count    (sample_count),
		.mean_shift      (mean_shift),
		.motion_detected (motion_detected),
		.motion_reported (motion_reported),
		.sample_overflow (sample_overflow)
	);

	// ---------------------------------------------------------------- bench state
	bit gaps_on  = 1'b1;  // random idle cycles on both channels
	bit hold_req = 1'b0;  // asks the hold process for one long receiver hold-off
	logic hold_on = 1'b0;

	int cycle_count        = 0;
	int errors             = 0;
	int pixels_sent        = 0;
	int frames_sent        = 0;
	int reports_checked    = 0;
	int overflow_reports   = 0;
	int reported_events    = 0;
	int input_stall_cycles = 0;

	// Shadow of the configuration registers, reset values
	logic [WIDTH_W-1:0]  m_width    = 13'd320;
	logic [STRIDE_W-1:0] m_stride   = 5'd4;
	logic [THR_W-1:0]    m_thr      = 8'd20;
	logic [RATIO_W-1:0]  m_ratio    = 17'd3277;
	logic [TIME_W-1:0]   m_cooldown = 32'd1000;

	// Frame state of the model; cleared after every end-of-frame beat
	int diff_mem [MAX_SAMPLES];
	int diff_acc  = 0;
	int n_stored  = 0;
	int col_pos   = 0;
	int row_pos   = 0;
	bit drop_seen = 1'b0;
	// Report history survives frames
	logic [TIME_W-1:0] last_report_ms = '0;
	bit                reported_once  = 1'b0;

	frame_report_t expected_reports [$];

	// ---------------------------------------------------------------- clock
	initial begin : clock_gen
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- model
	// Feeds one accepted pixel beat into the model; on end of frame it judges
	// the frame and queues the result the block must produce.
	task automatic account_pixel(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] c,
			input logic eof, input logic [TIME_W-1:0] now);
		int w, s, mean, dev, moving;
		logic [TIME_W-1:0] elapsed;
		frame_report_t r;
		// width 0 reads as 1, wider than MAX_WIDTH saturates; stride 0 reads as 1
		w = (m_width == 0) ? 1 : (m_width > MAX_WIDTH) ? MAX_WIDTH : int'(m_width);
		s = (m_stride == 0) ? 1 : int'(m_stride);
		if (col_pos % s == 0 && row_pos % s == 0) begin
			if (n_stored < MAX_SAMPLES) begin
				diff_mem[n_stored] = int'(c) - int'(p);
				diff_acc += diff_mem[n_stored];
				n_stored++;
			end else begin
				drop_seen = 1'b1;
			end
		end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1) % 4096;
		end else begin
			col_pos++;
		end
		if (eof) begin
			moving = 0;
			mean   = 0;
			r      = '0;
			if (n_stored > 0) begin
				mean = diff_acc / n_stored;   // truncates toward zero
				for (int k = 0; k < n_stored; k++) begin
					dev = diff_mem[k] - mean;
					if (dev < 0) dev = -dev;
					if (dev > int'(m_thr)) moving++;
				end
				r.detected = longint'(moving) * 65536 >= longint'(m_ratio) * n_stored;
			end
			if (r.detected) begin
				elapsed = now - last_report_ms;   // modulo 2^32
				if (!reported_once || elapsed >= m_cooldown) begin
					last_report_ms = now;
					reported_once  = 1'b1;
					r.reported     = 1'b1;
				end
			end
			r.moving   = moving[CNT_W-1:0];
			r.samples  = n_stored[CNT_W-1:0];
			r.mean     = mean[MEAN_W-1:0];
			r.overflow = drop_seen;
			expected_reports.push_back(r);
			diff_acc  = 0;
			n_stored  = 0;
			col_pos   = 0;
			row_pos   = 0;
			drop_seen = 1'b0;
			frames_sent++;
		end
	endtask

	// ---------------------------------------------------------------- pixel side
	// Offers one beat and returns at the edge that took it. Acceptance is
	// judged at the falling edge, where valid and stall are settled for the
	// next rising edge.
	task automatic drive_pixel(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] c,
			input logic eof, input logic [TIME_W-1:0] now);
		bit taken;
		while (gaps_on && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		prev_pixel    <= p;
		curr_pixel    <= c;
		end_of_frame  <= eof;
		frame_time_ms <= now;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		account_pixel(p, c, eof, now);
		pixels_sent++;
	endtask

	task automatic make_pair(input scene_t scene, input int shift,
			output logic [PIX_W-1:0] p, output logic [PIX_W-1:0] c);
		int v, jitter;
		p      = PIX_W'($urandom_range(255));
		jitter = $urandom_range(4);
		case (scene)
			SCENE_NOISE: c = PIX_W'($urandom_range(255));
			SCENE_LIT: begin
				v = int'(p) + shift + jitter - 2;
				if ($urandom_range(99) < 15) v = $urandom_range(255);   // a moving pixel
				v = (v < 0) ? 0 : (v > 255) ? 255 : v;
				c = v[PIX_W-1:0];
			end
			default: begin
				p = $urandom_range(1) ? 8'hFF : 8'h00;
				c = $urandom_range(1) ? 8'hFF : 8'h00;
			end
		endcase
	endtask

	// Time stamps of non-final pixels are ignored by the block, so they are random.
	task automatic send_frame(input int len, input scene_t scene, input int shift,
			input logic [TIME_W-1:0] stamp);
		logic [PIX_W-1:0] p, c;
		for (int i = 0; i < len; i++) begin
			make_pair(scene, shift, p, c);
			drive_pixel(p, c, i == len - 1, (i == len - 1) ? stamp : $urandom);
		end
	endtask

	task automatic send_uniform_frame(input int len, input logic [PIX_W-1:0] p,
			input logic [PIX_W-1:0] c, input logic [TIME_W-1:0] stamp);
		for (int i = 0; i < len; i++)
			drive_pixel(p, c, i == len - 1, (i == len - 1) ? stamp : $urandom);
	endtask

	// Differences +255 and -255: mean 0, both samples move at any threshold below 255
	task automatic opposite_pair_frame(input logic [TIME_W-1:0] stamp);
		drive_pixel(8'h00, 8'hFF, 1'b0, $urandom);
		drive_pixel(8'hFF, 8'h00, 1'b1, stamp);
	endtask

	// Drops valid and waits until every queued result is back, then lets the
	// back part settle so that registers can be written safely.
	task automatic wait_reports_drained();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- registers
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_FRAME_WIDTH:    m_width    = data[WIDTH_W-1:0];
			REG_SAMPLE_STRIDE:  m_stride   = data[STRIDE_W-1:0];
			REG_DIFF_THRESHOLD: m_thr      = data[THR_W-1:0];
			REG_MIN_RATIO:      m_ratio    = data[RATIO_W-1:0];
			REG_COOLDOWN:       m_cooldown = data[TIME_W-1:0];
			default: ;   // unmapped index: no effect
		endcase
	endtask

	task automatic set_config(input logic [WIDTH_W-1:0] w, input logic [STRIDE_W-1:0] s,
			input logic [THR_W-1:0] t, input logic [RATIO_W-1:0] r,
			input logic [TIME_W-1:0] cd);
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_SAMPLE_STRIDE, CFG_DATA_W'(s));
		write_reg(REG_DIFF_THRESHOLD, CFG_DATA_W'(t));
		write_reg(REG_MIN_RATIO, CFG_DATA_W'(r));
		write_reg(REG_COOLDOWN, cd);
	endtask

	// Random bits above a register's width; the block must ignore them
	function automatic logic [CFG_DATA_W-1:0] pad_upper(input logic [CFG_DATA_W-1:0] value,
			input int bits);
		logic [CFG_DATA_W-1:0] junk;
		junk = $urandom;
		return (bits >= CFG_DATA_W) ? value : ((junk << bits) | value);
	endfunction

	task automatic randomize_config();
		logic [WIDTH_W-1:0]  w;
		logic [STRIDE_W-1:0] s;
		logic [THR_W-1:0]    t;
		logic [RATIO_W-1:0]  r;
		logic [TIME_W-1:0]   cd;
		int pick;
		pick = $urandom_range(99);
		w = WIDTH_W'((pick < 70) ? $urandom_range(1, 24) : (pick < 80) ? 0 :
			(pick < 90) ? $urandom_range(25, 400) : $urandom_range(4097, 8191));
		pick = $urandom_range(99);
		s = STRIDE_W'((pick < 60) ? $urandom_range(1, 4) : (pick < 70) ? 0 :
			(pick < 90) ? $urandom_range(5, 16) : $urandom_range(17, 31));
		pick = $urandom_range(99);
		t = THR_W'((pick < 70) ? $urandom_range(40) : $urandom_range(255));
		pick = $urandom_range(99);
		r = RATIO_W'((pick < 60) ? $urandom_range(40000) : (pick < 70) ? 0 :
			(pick < 80) ? 65536 :
			(pick < 90) ? $urandom_range(65537, 131071) : $urandom_range(40000, 65535));
		pick = $urandom_range(99);
		cd = (pick < 40) ? $urandom_range(3000) : (pick < 55) ? 0 :
			(pick < 70) ? 32'hFFFF_FFFF : $urandom;
		write_reg(REG_FRAME_WIDTH, pad_upper(CFG_DATA_W'(w), WIDTH_W));
		write_reg(REG_SAMPLE_STRIDE, pad_upper(CFG_DATA_W'(s), STRIDE_W));
		write_reg(REG_DIFF_THRESHOLD, pad_upper(CFG_DATA_W'(t), THR_W));
		write_reg(REG_MIN_RATIO, pad_upper(CFG_DATA_W'(r), RATIO_W));
		write_reg(REG_COOLDOWN, pad_upper(cd, TIME_W));
	endtask

	// ---------------------------------------------------------------- result side
	task automatic check_report();
		frame_report_t got, want;
		got.moving   = moving_count;
		got.samples  = sample_count;
		got.mean     = mean_shift;
		got.detected = motion_detected;
		got.reported = motion_reported;
		got.overflow = sample_overflow;
		reports_checked++;
		if (expected_reports.size() == 0) begin
			if (errors < MAX_SHOWN)
				$display("cycle %0d: result beat with none pending: moving %0d samples %0d",
					cycle_count, got.moving, got.samples);
			errors++;
		end else begin
			want = expected_reports.pop_front();
			if (got.moving !== want.moving || got.samples !== want.samples ||
					got.mean !== want.mean || got.detected !== want.detected ||
					got.reported !== want.reported || got.overflow !== want.overflow) begin
				if (errors < MAX_SHOWN)
					$display({"cycle %0d result %0d (exp/got): moving %0d/%0d samples %0d/%0d",
						" mean %0d/%0d detected %0b/%0b reported %0b/%0b overflow %0b/%0b"},
						cycle_count, reports_checked, want.moving, got.moving,
						want.samples, got.samples, $signed(want.mean), $signed(got.mean),
						want.detected, got.detected, want.reported, got.reported,
						want.overflow, got.overflow);
				errors++;
			end
			if (want.overflow) overflow_reports++;
			if (want.reported) reported_events++;
		end
	endtask

	// Checks result beats at the falling edge and picks the next out_stall at
	// the rising edge; also counts cycles in which the block held off input.
	initial begin : result_monitor
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) check_report();
			if (arst_n && in_valid && in_stall) input_stall_cycles++;
			@(posedge clk);
			out_stall <= hold_on || (gaps_on && $urandom_range(99) < 16);
		end
	end

	// Long receiver hold-off, counted here so the sender keeps offering beats
	initial begin : receiver_hold
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles with %0d results outstanding",
			cycle_count, expected_reports.size());
		$display("FAILURE");
		$finish;
	end

	// ---------------------------------------------------------------- tests
	// Registers at reset: width 320, stride 4. The first frame ever detected is
	// reported even at time stamp zero, since nothing was reported before.
	task automatic test_reset_defaults();
		for (int i = 0; i < 20; i++) begin
			if ((i / 4) % 2 == 0) drive_pixel(8'h00, 8'hFF, i == 19, 32'd0);
			else                  drive_pixel(8'hFF, 8'h00, i == 19, 32'd0);
		end
		wait_reports_drained();
	endtask

	// Luma extremes, mean rounding on both signs, threshold ends, unmapped indexes
	task automatic test_pixel_extremes();
		for (int i = NUM_REGS; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), $urandom);
		set_config(13'd4, 5'd1, 8'd0, 17'd0, 32'd0);
		send_uniform_frame(6, 8'h00, 8'hFF, 32'hFFFF_FFFF);   // mean +255
		send_uniform_frame(6, 8'hFF, 8'h00, 32'h0000_0001);   // mean -255
		opposite_pair_frame($urandom);                        // both move at threshold 0
		// -3 and -4 average to -3, +3 and +4 to +3
		drive_pixel(8'd10, 8'd7, 1'b0, $urandom);
		drive_pixel(8'd10, 8'd6, 1'b1, 32'd50);
		drive_pixel(8'd7, 8'd10, 1'b0, $urandom);
		drive_pixel(8'd6, 8'd10, 1'b1, 32'd60);
		wait_reports_drained();
		write_reg(REG_DIFF_THRESHOLD, 32'd255);
		opposite_pair_frame($urandom);                        // 255 is not above 255
		wait_reports_drained();
	endtask

	// Ratio at exactly one and beyond, cooldown edges and wrap of the time stamp
	task automatic test_ratio_and_cooldown();
		set_config(13'd2, 5'd1, 8'd0, 17'd65536, 32'd1000);
		opposite_pair_frame(32'd5000);
		opposite_pair_frame(last_report_ms + 32'd999);        // one short of cooldown
		opposite_pair_frame(last_report_ms + 32'd1000);       // exactly cooldown
		opposite_pair_frame(last_report_ms - 32'd5);          // elapsed wraps modulo 2^32
		wait_reports_drained();
		write_reg(REG_MIN_RATIO, 32'd65537);                  // unreachable ratio
		opposite_pair_frame($urandom);
		wait_reports_drained();
		write_reg(REG_MIN_RATIO, 32'd131071);
		opposite_pair_frame($urandom);
		wait_reports_drained();
		write_reg(REG_MIN_RATIO, 32'd0);
		write_reg(REG_COOLDOWN, 32'hFFFF_FFFF);
		opposite_pair_frame(last_report_ms - 32'd1);          // elapsed is the full range
		opposite_pair_frame(last_report_ms + 32'd5);          // held off
		wait_reports_drained();
		write_reg(REG_COOLDOWN, 32'd0);
		opposite_pair_frame(32'd777);
		opposite_pair_frame(32'd777);                         // same stamp still reports
		wait_reports_drained();
	endtask

	// Width and stride limits, and the row counter wrapping at 4096
	task automatic test_sampling_geometry();
		set_config(13'd0, 5'd0, 8'd20, 17'd3277, 32'd1000);  // both read as one
		send_frame(5, SCENE_NOISE, 0, 32'd9000);
		wait_reports_drained();
		set_config(13'd3, 5'd17, 8'd20, 17'd3277, 32'd1000); // stride above 16 kept
		send_frame(60, SCENE_NOISE, 0, 32'd9100);
		wait_reports_drained();
		// clamp to 4096 shows on pixel 4097: column 4096 would be a sample
		set_config(13'd8191, 5'd16, 8'd10, 17'd3277, 32'd1000);
		send_frame(4100, SCENE_LIT, 3, 32'd9200);
		wait_reports_drained();
		// one column, stride 3: row 4096 wraps to row 0 and is sampled again
		set_config(13'd1, 5'd3, 8'd10, 17'd3277, 32'd1000);
		send_frame(4100, SCENE_LIT, -5, 32'd9300);
		wait_reports_drained();
	endtask

	// Exactly full store, then samples dropped; the flag clears with the frame
	task automatic test_full_buffer();
		set_config(13'd64, 5'd1, 8'd12, 17'd3277, 32'd500);
		send_frame(MAX_SAMPLES, SCENE_LIT, -7, 32'd20000);
		send_frame(MAX_SAMPLES + 4, SCENE_NOISE, 0, 32'd21000);
		send_frame(8, SCENE_LIT, 2, 32'd22000);
		wait_reports_drained();
	endtask

	// No idle cycles on either side
	task automatic test_back_to_back();
		int sent, start;
		set_config(13'd5, 5'd2, 8'd8, 17'd6000, 32'd100);
		gaps_on = 1'b0;
		start = pixels_sent;
		sent = 0;
		while (sent < 300) begin
			send_frame($urandom_range(1, 30), SCENE_LIT, 4, 32'd30000 + sent * 40);
			sent = pixels_sent - start;
		end
		gaps_on = 1'b1;
		wait_reports_drained();
	endtask

	// Receiver holds off for a long stretch while short frames keep coming,
	// so the job queue and both banks fill and input stalls.
	task automatic test_input_backpressure();
		set_config(13'd8, 5'd1, 8'd10, 17'd8000, 32'd250);
		hold_req = 1'b1;
		for (int f = 0; f < 40; f++)
			send_frame($urandom_range(4, 12), SCENE_LIT, -3, 32'd40000 + f * 100);
		wait_reports_drained();
	endtask

	// Mostly well-formed frames with brightness shifts under random settings,
	// mixed with noise and saturated frames.
	task automatic test_random_frames();
		int random_pixels, pick, len, shift;
		scene_t scene;
		logic [TIME_W-1:0] stamp_ms;
		random_pixels = 0;
		stamp_ms = $urandom;
		while (random_pixels < RANDOM_PIXELS) begin
			randomize_config();
			repeat ($urandom_range(2, 6)) begin
				pick = $urandom_range(99);
				len = (pick < 85) ? $urandom_range(1, 48) : $urandom_range(49, 200);
				pick = $urandom_range(99);
				scene = (pick < 60) ? SCENE_LIT : (pick < 85) ? SCENE_NOISE : SCENE_EXTREME;
				shift = int'($urandom_range(60)) - 30;
				if ($urandom_range(99) < 10) shift = shift * 7;
				pick = $urandom_range(99);
				if (pick < 60)      stamp_ms += $urandom_range(3000);
				else if (pick < 75) stamp_ms = stamp_ms;          // repeated stamp
				else if (pick < 90) stamp_ms = $urandom;
				else                stamp_ms -= $urandom_range(1, 100);
				send_frame(len, scene, shift, stamp_ms);
				random_pixels += len;
			end
			wait_reports_drained();
		end
	endtask

	// ---------------------------------------------------------------- sequence
	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_pixel_extremes();
		test_ratio_and_cooldown();
		test_sampling_geometry();
		test_full_buffer();
		test_back_to_back();
		test_input_backpressure();
		test_random_frames();
		wait_reports_drained();
		$display("Covered %0d pixel beats in %0d frames; %0d result beats checked.",
			pixels_sent, frames_sent, reports_checked);
		$display("%0d frames dropped samples, %0d reported motion, input held off %0d cycles.",
			overflow_reports, reported_events, input_stall_cycles);
		if (errors == 0 && expected_reports.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
rtl/fdm_pkg.sv
rtl/fdm_diff_ram.sv
rtl/fdm_job_queue.sv
rtl/fdm_front.sv
rtl/fdm_back.sv
rtl/frame_diff_motion_counter.sv
bench/tb_frame_diff_motion_counter.sv
